@@ sv/pktdf_pkg.sv @@
// Shared types, codes and CRC helper for the packet deframer.
package pktdf_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_TIMEOUT = 2'd1,
    KIND_READ    = 2'd2
  } kind_t;

  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  localparam logic [7:0]  START_RESET   = 8'h02;
  localparam logic [31:0] TIMEOUT_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam int unsigned HDR_BYTES     = 7;

  // CRC-16 CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ sv/packet_deframer_crc16.sv @@
// Packet deframer: start-byte hunt, 7-byte header, payload store, CRC-16 CCITT check.
// Latency: a result is shown the cycle after its item is accepted.
// Throughput: one item per cycle while in_stall is low; the whole byte step (CRC byte update, header
// and length compare, one store access) sits between the state and the result register.
// in_stall is high only while a result is held and out_stall is high.
// Reset clears frame state, tick count and output valid, presets config; the payload store is kept.
module packet_deframer_crc16 #(
  parameter int MAX_PAYLOAD = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_en,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pktdf_pkg::op_t          op,
  input  logic [7:0]              rx_byte,
  input  logic [11:0]             read_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pktdf_pkg::kind_t        kind,
  output logic [7:0]              command,
  output logic [12:0]             payload_length,
  output logic [7:0]              read_data
);
  import pktdf_pkg::*;

  localparam int PW = $clog2(MAX_PAYLOAD + 9);
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    start_byte;
  logic [31:0]   timeout_ticks;

  logic [PW-1:0] pos, pos_next;
  logic          hdr_done, hdr_done_next;
  logic [31:0]   len_field, len_field_next;
  logic [7:0]    cmd_held, cmd_held_next;
  logic [15:0]   crc, crc_next;
  logic [7:0]    crc_lo, crc_lo_next;
  logic [31:0]   ticks, ticks_next;

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    rd_q;
  logic          rd_ok;

  logic          accept;
  logic          res_valid;
  kind_t         res_kind;
  logic [7:0]    res_cmd;
  logic [12:0]   res_len;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [31:0]   off;
  logic [15:0]   crc_upd;
  logic [1:0]    lane;
  logic          rd_in_range;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign off         = 32'(pos) - 32'(HDR_BYTES);
  assign crc_upd     = crc16_feed(crc, rx_byte);
  assign lane        = 2'(pos - PW'(3));
  assign waddr       = AW'(off);
  assign rd_in_range = 32'(read_index) < 32'(MAX_PAYLOAD);

  always_comb begin
    pos_next       = pos;
    hdr_done_next  = hdr_done;
    len_field_next = len_field;
    cmd_held_next  = cmd_held;
    crc_next       = crc;
    crc_lo_next    = crc_lo;
    ticks_next     = ticks;
    res_valid      = 1'b0;
    res_kind       = KIND_READ;
    res_cmd        = 8'h00;
    res_len        = 13'd0;
    mem_we         = 1'b0;

    case (op)
      OP_READ: begin
        res_valid = 1'b1;
        res_kind  = KIND_READ;
      end
      OP_TICK: begin
        if ({1'b0, ticks} + 33'd1 >= {1'b0, timeout_ticks}) begin
          pos_next       = '0;
          hdr_done_next  = 1'b0;
          len_field_next = '0;
          cmd_held_next  = '0;
          crc_next       = CRC_INIT;
          crc_lo_next    = '0;
          ticks_next     = '0;
          res_valid      = 1'b1;
          res_kind       = KIND_TIMEOUT;
        end else begin
          ticks_next = ticks + 32'd1;
        end
      end
      OP_BYTE: begin
        if (pos == '0 && rx_byte != start_byte) begin
          pos_next = pos;
        end else if (!hdr_done) begin
          crc_next = crc_upd;
          if (pos == PW'(2)) begin
            cmd_held_next = rx_byte;
          end else if (pos >= PW'(3)) begin
            len_field_next[8*lane +: 8] = rx_byte;
          end
          pos_next = pos + PW'(1);
          if (pos == PW'(HDR_BYTES - 1)) begin
            if (len_field_next > 32'(MAX_PAYLOAD)) begin
              pos_next       = '0;
              hdr_done_next  = 1'b0;
              len_field_next = '0;
              cmd_held_next  = '0;
              crc_next       = CRC_INIT;
              crc_lo_next    = '0;
            end else begin
              hdr_done_next = 1'b1;
            end
          end
        end else if (off < len_field) begin
          crc_next = crc_upd;
          mem_we   = 1'b1;
          pos_next = pos + PW'(1);
        end else if (off == len_field) begin
          crc_lo_next = rx_byte;
          pos_next    = pos + PW'(1);
        end else begin
          pos_next       = '0;
          hdr_done_next  = 1'b0;
          len_field_next = '0;
          cmd_held_next  = '0;
          crc_next       = CRC_INIT;
          crc_lo_next    = '0;
          if ({rx_byte, crc_lo} == crc) begin
            ticks_next = '0;
            res_valid  = 1'b1;
            res_kind   = KIND_FRAME;
            res_cmd    = cmd_held;
            res_len    = 13'(len_field);
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // payload store
  always_ff @(posedge clk) begin
    if (accept && mem_we && op == OP_BYTE) begin
      mem[waddr] <= rx_byte;
    end
    if (accept && op == OP_READ) begin
      rd_q  <= mem[AW'(read_index)];
      rd_ok <= rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      pos           <= '0;
      hdr_done      <= 1'b0;
      len_field     <= '0;
      cmd_held      <= '0;
      crc           <= CRC_INIT;
      crc_lo        <= '0;
      ticks         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == CFG_START_BYTE) begin
          start_byte <= cfg_data[7:0];
        end else begin
          timeout_ticks <= cfg_data;
        end
      end
      if (accept) begin
        pos       <= pos_next;
        hdr_done  <= hdr_done_next;
        len_field <= len_field_next;
        cmd_held  <= cmd_held_next;
        crc       <= crc_next;
        crc_lo    <= crc_lo_next;
        ticks     <= ticks_next;
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind           <= res_kind;
      command        <= res_cmd;
      payload_length <= res_len;
    end
  end

  assign read_data = (kind == KIND_READ && rd_ok) ? rd_q : 8'h00;

endmodule

@@ sim/packet_deframer_crc16_tb.sv @@
// Self-checking testbench for packet_deframer_crc16: random framed traffic checked against a predictor.
`timescale 1ns / 100ps

module packet_deframer_crc16_tb;
  import pktdf_pkg::*;

  localparam int PAYLOAD_CAP = 4096;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {CLEAN, BAD_CRC, OVERSIZE} flaw_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  command;
    logic [12:0] length;
    logic [7:0]  data;
  } deframe_result_t;

  class frame_scoreboard;
    logic [7:0]  store [PAYLOAD_CAP];
    int          written_top;
    int unsigned pos;
    bit          hdr_done;
    logic [31:0] len_field;
    logic [7:0]  cmd_held;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    logic [31:0] ticks;
    logic [7:0]  start_byte;
    logic [31:0] timeout;
    deframe_result_t due[$];
    int errors, frames_ok, timeouts, reads, used_items;

    function new();
      restart();
      ticks = '0;
      start_byte = START_RESET;
      timeout = TIMEOUT_RESET;
      written_top = 0;
      errors = 0;
      frames_ok = 0;
      timeouts = 0;
      reads = 0;
      used_items = 0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void restart();
      pos = 0;
      hdr_done = 1'b0;
      len_field = '0;
      cmd_held = '0;
      crc = CRC_INIT;
      crc_lo = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == CFG_START_BYTE) begin
        start_byte = val[7:0];
      end else begin
        timeout = val;
      end
    endfunction

    function void note_item(op_t o, logic [7:0] b, logic [11:0] idx);
      deframe_result_t r;
      int unsigned off;
      bit ok;
      r.kind = KIND_READ;
      r.command = '0;
      r.length = '0;
      r.data = '0;
      case (o)
        OP_READ: begin
          used_items++;
          reads++;
          r.data = store[idx];
          due.push_back(r);
        end
        OP_TICK: begin
          used_items++;
          if ({1'b0, ticks} + 33'd1 >= {1'b0, timeout}) begin
            restart();
            ticks = '0;
            timeouts++;
            r.kind = KIND_TIMEOUT;
            due.push_back(r);
          end else begin
            ticks++;
          end
        end
        OP_BYTE: begin
          if (pos == 0 && b != start_byte) return;
          used_items++;
          if (!hdr_done) begin
            crc = crc_byte(crc, b);
            if (pos == 2) begin
              cmd_held = b;
            end else if (pos >= 3) begin
              len_field[8*(pos-3) +: 8] = b;
            end
            pos++;
            if (pos == HDR_BYTES) begin
              if (len_field > PAYLOAD_CAP) begin
                restart();
              end else begin
                hdr_done = 1'b1;
              end
            end
          end else begin
            off = pos - HDR_BYTES;
            if (off < len_field) begin
              crc = crc_byte(crc, b);
              store[off] = b;
              if (off + 1 > written_top) written_top = off + 1;
              pos++;
            end else if (off == len_field) begin
              crc_lo = b;
              pos++;
            end else begin
              ok = ({b, crc_lo} == crc);
              r.command = cmd_held;
              r.length = len_field[12:0];
              restart();
              if (ok) begin
                ticks = '0;
                frames_ok++;
                r.kind = KIND_FRAME;
                due.push_back(r);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [12:0] want, logic [12:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(kind_t k, logic [7:0] c, logic [12:0] n, logic [7:0] d);
      deframe_result_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d cmd %0h len %0d data %0h",
                 $time, k, c, n, d);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("kind", want.kind, k);
      compare_field("command", want.command, c);
      compare_field("payload_length", want.length, n);
      compare_field("read_data", want.data, d);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_en;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  op_t         op;
  logic [7:0]  rx_byte;
  logic [11:0] read_index;
  logic        out_valid;
  logic        out_stall;
  kind_t       kind;
  logic [7:0]  command;
  logic [12:0] payload_length;
  logic [7:0]  read_data;

  frame_scoreboard sb;
  bit drv_idle = 1'b1;
  bit rcv_idle = 1'b1;
  int cycle_count = 0;

  packet_deframer_crc16 u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .rx_byte        (rx_byte),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .command        (command),
    .payload_length (payload_length),
    .read_data      (read_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic push_item(input op_t o, input logic [7:0] b, input logic [11:0] idx);
    int gap;
    gap = drv_idle ? $urandom_range(0, 3) : 0;
    if ($urandom_range(0, 39) == 0) drv_idle = !drv_idle;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(o, b, idx);
  endtask

  task automatic read_payload;
    if (sb.written_top > 0) begin
      push_item(OP_READ, 8'($urandom), 12'($urandom_range(0, sb.written_top - 1)));
    end
  endtask

  task automatic send_frame(input flaw_t flaw, input logic [7:0] cmd, input logic [31:0] len,
                            input bit chatter);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    frame_bytes.push_back(sb.start_byte);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(cmd);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(len[8*i +: 8]);
    if (flaw != OVERSIZE) begin
      for (int i = 0; i < int'(len); i++) frame_bytes.push_back(8'($urandom));
      crc = CRC_INIT;
      foreach (frame_bytes[i]) crc = sb.crc_byte(crc, frame_bytes[i]);
      if (flaw == BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
    end
    foreach (frame_bytes[i]) begin
      if (chatter && $urandom_range(0, 11) == 0) read_payload();
      if (chatter && $urandom_range(0, 29) == 0) begin
        push_item(OP_TICK, 8'($urandom), 12'($urandom));
      end
      push_item(OP_BYTE, frame_bytes[i], 12'($urandom));
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [7:0] start, input logic [31:0] limit);
    drain();
    write_reg(CFG_START_BYTE, {24'($urandom), start});
    write_reg(CFG_TIMEOUT, limit);
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] b;
    logic [31:0] big_len;
    int goal;
    int sel;
    sb = new();
    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = CFG_START_BYTE;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_BYTE;
    rx_byte = '0;
    read_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(START_RESET, TIMEOUT_RESET);
    push_item(op_t'(2'd3), 8'hFF, 12'hFFF);
    push_item(OP_BYTE, 8'h00, 12'h000);
    send_frame(CLEAN, 8'hFF, 32'd1, 1'b0);
    push_item(OP_READ, 8'h00, 12'd0);
    send_frame(BAD_CRC, 8'h00, 32'd0, 1'b0);
    send_frame(OVERSIZE, 8'h5A, 32'd4097, 1'b0);
    push_item(OP_TICK, 8'h00, 12'h000);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(8'h00, 32'd0);
        1: configure(8'hFF, 32'd1);
        2: configure(8'($urandom), $urandom_range(2, 40));
        3: configure(8'($urandom), $urandom | 32'h0001_0000);
        default: configure(8'h7E, $urandom_range(5, 200));
      endcase
      goal = sb.used_items + 250;
      while (sb.used_items < goal) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          send_frame(CLEAN, 8'($urandom),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(17, 96) : $urandom_range(0, 16),
                     1'b1);
        end else if (sel < 68) begin
          send_frame(BAD_CRC, 8'($urandom), $urandom_range(0, 12), 1'b1);
        end else if (sel < 73) begin
          case ($urandom_range(0, 2))
            0: big_len = 32'd4097;
            1: big_len = 32'hFFFF_FFFF;
            default: big_len = $urandom | 32'h0000_2000;
          endcase
          send_frame(OVERSIZE, 8'($urandom), big_len, 1'b1);
        end else if (sel < 83) begin
          push_item(OP_TICK, 8'($urandom), 12'($urandom));
        end else if (sel < 93) begin
          read_payload();
        end else if (sel < 97) begin
          do b = 8'($urandom); while (b == sb.start_byte);
          push_item(OP_BYTE, b, 12'($urandom));
        end else begin
          push_item(op_t'(2'd3), 8'($urandom), 12'($urandom));
        end
      end
    end

    // longer payload, then reads across the written part of the store
    configure(8'($urandom), TIMEOUT_RESET);
    send_frame(CLEAN, 8'($urandom), 32'd96, 1'b0);
    push_item(OP_READ, 8'($urandom), 12'(sb.written_top - 1));
    push_item(OP_READ, 8'($urandom), 12'(sb.written_top / 2));
    push_item(OP_READ, 8'($urandom), 12'd0);
    repeat (20) read_payload();
    push_item(OP_TICK, 8'($urandom), 12'($urandom));

    drain();
    $display("Covered %0d items over 7 register settings: %0d good frames, %0d timeouts,",
             sb.used_items, sb.frames_ok, sb.timeouts);
    $display("%0d payload reads, plus bad CRC, oversized length and ignored-op traffic.",
             sb.reads);
    if (sb.errors == 0) begin
      $display("PASS packet_deframer_crc16");
    end else begin
      $display("FAIL packet_deframer_crc16");
    end
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(kind, command, payload_length, read_data);
        hold = rcv_idle ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 39) == 0) rcv_idle = !rcv_idle;
      end
      @(negedge clk);
      out_stall <= (hold != 0);
      if (hold != 0) hold--;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("FAIL packet_deframer_crc16");
    $finish;
  end

endmodule
